[rtl/sorted_max_priority_queue_macros.svh]
// assertion macros shared by the checker of the priority queue
`ifndef SORTED_MAX_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_MAX_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SMPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SMPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/smpq_pkg.sv]
// types and codes shared by the sorted priority queue modules
package smpq_pkg;

    localparam int VALUE_W = 32;
    localparam int OCC_W   = 5;

    // operation codes carried by an input item
    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // what every cell does with its entry
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } cell_op_t;

    // broadcast from the control to all cells
    typedef struct packed {
        cell_op_t                   op;
        logic signed [VALUE_W-1:0]  value;
    } cell_ctrl_t;

    // handed from one cell to the next one down the row; its value also goes up to the cell before
    typedef struct packed {
        logic                       gt;
        logic signed [VALUE_W-1:0]  value;
    } cell_link_t;

endpackage

[rtl/sorted_max_priority_queue.sv]
// Sorted max-priority queue: a row of CAPACITY cells keeps the stored values in
// descending order, largest in the first cell. Every cell compares its entry with
// the incoming value in parallel. One item is accepted per cycle unless a stalled
// result holds the input off, and its result appears in the output register on the
// next cycle. The next item is taken in the same cycle that the waiting result is
// taken; throughput is set by the compare-and-shift of the cell row. No clearing
// pass is needed after reset.
module sorted_max_priority_queue
#(
    parameter int CAPACITY = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          command,
    input  logic signed [smpq_pkg::VALUE_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic signed [smpq_pkg::VALUE_W-1:0] top_value,
    output logic [smpq_pkg::OCC_W-1:0]          occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                                accept;
    smpq_pkg::cmd_t                      cmd;
    smpq_pkg::cell_ctrl_t                ctrl;
    smpq_pkg::cell_link_t                links [CAPACITY];
    logic [CAPACITY-1:0]                 occupied;

    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    count_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    smpq_pkg::status_t                   status_reg;
    smpq_pkg::status_t                   status_next;
    logic signed [smpq_pkg::VALUE_W-1:0] top_reg;
    logic signed [smpq_pkg::VALUE_W-1:0] top_next;
    logic [smpq_pkg::OCC_W-1:0]          occ_reg;
    logic [smpq_pkg::OCC_W-1:0]          occ_next;

    // handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign cmd      = smpq_pkg::cmd_t'(command);

    // decode the item into a cell operation and the result
    always_comb
    begin
        ctrl.op     = smpq_pkg::OP_HOLD;
        ctrl.value  = value;
        count_next  = count_reg;
        status_next = smpq_pkg::ST_OK;
        top_next    = '0;
        case (cmd)
            smpq_pkg::CMD_ENQUEUE:
            begin
                if (count_reg == CNT_W'(CAPACITY))
                    status_next = smpq_pkg::ST_FULL;
                else
                begin
                    ctrl.op    = smpq_pkg::OP_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            smpq_pkg::CMD_DEQUEUE:
            begin
                if (count_reg == '0)
                    status_next = smpq_pkg::ST_EMPTY;
                else
                begin
                    ctrl.op    = smpq_pkg::OP_REMOVE;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            smpq_pkg::CMD_PEEK:
            begin
                if (count_reg == '0)
                    status_next = smpq_pkg::ST_EMPTY;
                else
                    top_next = links[0].value;
            end
            default:
            begin
                if (count_reg == '0)
                    status_next = smpq_pkg::ST_EMPTY;
                else
                    count_next = '0;
            end
        endcase
        if (!accept)
        begin
            ctrl.op    = smpq_pkg::OP_HOLD;
            count_next = count_reg;
        end
        occ_next = smpq_pkg::OCC_W'(count_next);
    end

    // output register load
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // the row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        smpq_pkg::cell_link_t                prev_link;
        logic signed [smpq_pkg::VALUE_W-1:0] next_value;

        assign occupied[i] = CNT_W'(i) < count_reg;

        if (i == 0)
        begin : g_first
            assign prev_link.gt    = 1'b1;
            assign prev_link.value = '0;
        end
        else
        begin : g_mid
            assign prev_link = links[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_value = links[i].value;
        end
        else
        begin : g_inner
            assign next_value = links[i+1].value;
        end

        smpq_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (occupied[i]),
            .prev_link  (prev_link),
            .next_value (next_value),
            .link       (links[i])
        );
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            top_reg    <= top_next;
            occ_reg    <= occ_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign top_value = top_reg;
    assign occupancy = occ_reg;

endmodule

[rtl/smpq_cell.sv]
// one storage cell of the sorted row: compare, hold, insert or shift
module smpq_cell
(
    input  logic                                clk,
    input  smpq_pkg::cell_ctrl_t                ctrl,
    input  logic                                occupied,
    input  smpq_pkg::cell_link_t                prev_link,
    input  logic signed [smpq_pkg::VALUE_W-1:0] next_value,
    output smpq_pkg::cell_link_t                link
);

    logic signed [smpq_pkg::VALUE_W-1:0] value_reg;
    logic signed [smpq_pkg::VALUE_W-1:0] value_next;
    logic                                gt;

    // stored entry beats the incoming value
    assign gt = occupied && ($signed(value_reg) > $signed(ctrl.value));

    assign link.gt    = gt;
    assign link.value = value_reg;

    // choose the new content of this cell
    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            smpq_pkg::OP_INSERT:
            begin
                if (gt)
                    value_next = value_reg;
                else if (prev_link.gt)
                    value_next = ctrl.value;
                else
                    value_next = prev_link.value;
            end
            smpq_pkg::OP_REMOVE:
                value_next = next_value;
            default:
                value_next = value_reg;
        endcase
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

[rtl/smpq_checker.sv]
// port-level checker for the sorted priority queue, bound to the top level
`include "sorted_max_priority_queue_macros.svh"

module smpq_checker
#(
    parameter int CAPACITY = 16
)
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic [1:0]                          command,
    input logic signed [smpq_pkg::VALUE_W-1:0] value,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [1:0]                          status,
    input logic signed [smpq_pkg::VALUE_W-1:0] top_value,
    input logic [smpq_pkg::OCC_W-1:0]          occupancy
);

    // an accepted item has its result waiting on the next cycle
    `SMPQ_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid,
        "accepted item gave no result")

    // a waiting input item holds until it is taken
    `SMPQ_ASSERT_NEXT(a_item_holds, in_valid && !in_ready,
        in_valid && $stable(command) && $stable(value), "waiting input item changed")

    // a stalled result holds
    `SMPQ_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(top_value) && $stable(occupancy),
        "stalled result changed")

    // only a successful peek shows a value
    `SMPQ_ASSERT_NOW(a_top_zero, out_valid && status != smpq_pkg::ST_OK, top_value == '0,
        "top value not zero on a failed item")

    // full means the occupancy sits at capacity, empty means nothing stored
    `SMPQ_ASSERT_NOW(a_fail_occ, out_valid && status != smpq_pkg::ST_OK,
        (status == smpq_pkg::ST_EMPTY) ? (occupancy == '0) :
        (occupancy == smpq_pkg::OCC_W'(CAPACITY)), "failed item with wrong occupancy")

endmodule

bind sorted_max_priority_queue smpq_checker #(.CAPACITY(CAPACITY)) u_smpq_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .top_value (top_value),
    .occupancy (occupancy)
);

[tb/sorted_max_priority_queue_checker.sv]
// checker for the sorted priority queue: tracks the queue contents, predicts and compares results
`timescale 1ns / 1ps

module sorted_max_priority_queue_checker
#(
    parameter int CAPACITY = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [1:0]                          command,
    input  logic signed [smpq_pkg::VALUE_W-1:0] value,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [1:0]                          status,
    input  logic signed [smpq_pkg::VALUE_W-1:0] top_value,
    input  logic [smpq_pkg::OCC_W-1:0]          occupancy,
    output int                                  errors,
    output int                                  pending
);

    // one predicted result item
    typedef struct packed {
        smpq_pkg::status_t                    st;
        logic signed [smpq_pkg::VALUE_W-1:0]  top;
        logic [smpq_pkg::OCC_W-1:0]           occ;
    } queue_answer_t;

    // shadow copy of the queue, largest value first
    logic signed [smpq_pkg::VALUE_W-1:0] shadow_slots [CAPACITY];
    int                                  held;

    // results still owed by the block, oldest first
    queue_answer_t awaited [$];
    queue_answer_t fresh;
    queue_answer_t oldest;

    // apply one command to the shadow queue and return what the block should answer
    function automatic queue_answer_t serve_command(
        input smpq_pkg::cmd_t op,
        input logic signed [smpq_pkg::VALUE_W-1:0] v);
        queue_answer_t r;
        int pos;
        r.st  = smpq_pkg::ST_OK;
        r.top = '0;
        case (op)
            smpq_pkg::CMD_ENQUEUE:
            begin
                if (held >= CAPACITY)
                begin
                    r.st = smpq_pkg::ST_FULL;
                end
                else
                begin
                    // new value goes in front of the first entry not greater than it
                    pos = 0;
                    while (pos < held && shadow_slots[pos] > v)
                        pos++;
                    for (int i = held; i > pos; i--)
                        shadow_slots[i] = shadow_slots[i-1];
                    shadow_slots[pos] = v;
                    held++;
                end
            end
            smpq_pkg::CMD_DEQUEUE:
            begin
                if (held == 0)
                begin
                    r.st = smpq_pkg::ST_EMPTY;
                end
                else
                begin
                    for (int i = 0; i + 1 < held; i++)
                        shadow_slots[i] = shadow_slots[i+1];
                    held--;
                end
            end
            smpq_pkg::CMD_PEEK:
            begin
                if (held == 0)
                    r.st = smpq_pkg::ST_EMPTY;
                else
                    r.top = shadow_slots[0];
            end
            default:
            begin
                if (held == 0)
                    r.st = smpq_pkg::ST_EMPTY;
                else
                    held = 0;
            end
        endcase
        r.occ = held[smpq_pkg::OCC_W-1:0];
        return r;
    endfunction

    // predict on every accepted input item, compare every accepted result item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held    = 0;
            errors  = 0;
            pending = 0;
            awaited.delete();
        end
        else
        begin
            // input side first, so a same-cycle result still pairs with the oldest item
            if (in_valid && in_ready)
            begin
                fresh = serve_command(smpq_pkg::cmd_t'(command), value);
                awaited.push_back(fresh);
            end
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t: result item with none expected: status %0d top %0d occ %0d",
                             $time, status, top_value, occupancy);
                    errors++;
                end
                else
                begin
                    oldest = awaited.pop_front();
                    if (status !== oldest.st)
                    begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, oldest.st, status);
                        errors++;
                    end
                    if (top_value !== oldest.top)
                    begin
                        $display("%0t: top_value mismatch, expected %0d, got %0d",
                                 $time, oldest.top, top_value);
                        errors++;
                    end
                    if (occupancy !== oldest.occ)
                    begin
                        $display("%0t: occupancy mismatch, expected %0d, got %0d",
                                 $time, oldest.occ, occupancy);
                        errors++;
                    end
                end
            end
            pending = awaited.size();
        end
    end

endmodule

[tb/tb_sorted_max_priority_queue.sv]
// top of the priority queue testbench: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_sorted_max_priority_queue;

    localparam int CAPACITY    = 16;
    localparam int RANDOM_OPS  = 700;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 250;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    logic [1:0]                          command;
    logic signed [smpq_pkg::VALUE_W-1:0] value;
    logic                                out_valid;
    logic                                out_ready;
    logic [1:0]                          status;
    logic signed [smpq_pkg::VALUE_W-1:0] top_value;
    logic [smpq_pkg::OCC_W-1:0]          occupancy;

    int fault_count;
    int awaited_count;
    int sent_items = 0;
    int quiet_cycles = 0;

    sorted_max_priority_queue #(.CAPACITY(CAPACITY)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .top_value (top_value),
        .occupancy (occupancy)
    );

    sorted_max_priority_queue_checker #(.CAPACITY(CAPACITY)) u_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .top_value (top_value),
        .occupancy (occupancy),
        .errors    (fault_count),
        .pending   (awaited_count)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // offer one item after a random gap, hold it until it is taken
    task automatic offer_item(input smpq_pkg::cmd_t op,
                              input logic signed [smpq_pkg::VALUE_W-1:0] v);
        int gap;
        // every third run of 64 items goes without gaps
        gap = ((sent_items / 64) % 3 == 1) ? 0 : $urandom_range(7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= op;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        sent_items++;
        @(negedge clk);
    endtask

    // stop offering until every outstanding result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (awaited_count != 0);
    endtask

    // priority value: mostly full range, often a narrow band for ties, sometimes extremes
    function automatic logic signed [smpq_pkg::VALUE_W-1:0] random_priority();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
            return int'($urandom_range(8)) - 4;
        else if (pick < 35)
        begin
            case ($urandom_range(3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // result side: random stalls, one long hold-off that backs the queue up
    initial
    begin : result_side
        int stall;
        int taken;
        out_ready = 1'b0;
        taken = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = ((taken / 64) % 3 == 1) ? 0 : $urandom_range(7);
            if (taken == 300)
                stall = LONG_HOLD;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
            @(negedge clk);
        end
    end

    // watchdog: too long without any item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        int             pick;
        int             phase;
        smpq_pkg::cmd_t op;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        command  = smpq_pkg::CMD_ENQUEUE;
        value    = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty queue on every command that reads or removes
        offer_item(smpq_pkg::CMD_PEEK,    32'sd5);
        offer_item(smpq_pkg::CMD_DEQUEUE, -32'sd5);
        offer_item(smpq_pkg::CMD_CLEAR,   32'sh7FFF_FFFF);
        // extremes and ties
        offer_item(smpq_pkg::CMD_ENQUEUE, 32'sh7FFF_FFFF);
        offer_item(smpq_pkg::CMD_ENQUEUE, 32'sh8000_0000);
        offer_item(smpq_pkg::CMD_ENQUEUE, 32'sd0);
        offer_item(smpq_pkg::CMD_ENQUEUE, -32'sd1);
        offer_item(smpq_pkg::CMD_ENQUEUE, 32'sd0);
        offer_item(smpq_pkg::CMD_ENQUEUE, 32'sd1);
        offer_item(smpq_pkg::CMD_PEEK,    32'sd0);
        offer_item(smpq_pkg::CMD_DEQUEUE, 32'sd0);
        offer_item(smpq_pkg::CMD_PEEK,    32'sd0);
        // fill to capacity, then one enqueue too many
        for (int k = 0; k < 11; k++)
            offer_item(smpq_pkg::CMD_ENQUEUE,
                       (k % 3 == 0) ? 32'sd0 : (k * 12345) - 60000);
        offer_item(smpq_pkg::CMD_ENQUEUE, 32'sh8000_0000);
        offer_item(smpq_pkg::CMD_PEEK,    32'sd0);
        offer_item(smpq_pkg::CMD_CLEAR,   32'sd0);
        wait_drained();

        // random part in phases that fill, drain and mix
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n == 450)
                wait_drained();
            phase = (n / 40) % 3;
            pick  = $urandom_range(99);
            case (phase)
                0:
                    op = (pick < 80) ? smpq_pkg::CMD_ENQUEUE :
                         (pick < 90) ? smpq_pkg::CMD_PEEK : smpq_pkg::CMD_DEQUEUE;
                1:
                    op = (pick < 70) ? smpq_pkg::CMD_DEQUEUE :
                         (pick < 85) ? smpq_pkg::CMD_PEEK :
                         (pick < 90) ? smpq_pkg::CMD_CLEAR : smpq_pkg::CMD_ENQUEUE;
                default:
                    op = (pick < 45) ? smpq_pkg::CMD_ENQUEUE :
                         (pick < 75) ? smpq_pkg::CMD_DEQUEUE :
                         (pick < 95) ? smpq_pkg::CMD_PEEK : smpq_pkg::CMD_CLEAR;
            endcase
            offer_item(op, random_priority());
        end

        // let the last results come back, then wait a little before the verdict
        wait_drained();
        repeat (4) @(negedge clk);
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
